/* rtl/core/buffer_slot_selector_assert.svh */
// Assertion macros shared by the buffer slot selector RTL.
`ifndef BUFFER_SLOT_SELECTOR_ASSERT_SVH
`define BUFFER_SLOT_SELECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bss_pkg.sv */
// Package with the types and constants of the buffer slot selector.
package bss_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [63:0] WEIGHT_NONE = '1;

   localparam logic [1:0] MODE_FIND_FIRST  = 2'd0;
   localparam logic [1:0] MODE_FIND_OLDEST = 2'd1;
   localparam logic [1:0] MODE_UPDATE      = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  state_code;
      logic [7:0]  slot_index;
      logic [63:0] new_weight;
   } bss_req_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] slot_out;
   } bss_rsp_type;

   // Search token handed from cell to cell.
   typedef struct packed {
      logic [1:0]            mode;
      logic [7:0]            code;
      logic [7:0]            slot;
      logic [63:0]           weight;
      logic [63:0]           best;
      logic                  found;
      logic [SLOT_IDX_W-1:0] best_idx;
   } bss_token_type;

endpackage

/* rtl/core/bss_cell.sv */
// One slot of the table: holds state and weight and updates the passing token.
module bss_cell
   import bss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SLOT_IDX_W-1:0] cell_index,
   input  logic                  in_valid,
   input  bss_token_type         in_tok,
   output logic                  out_valid,
   output bss_token_type         out_tok
);

   logic [7:0]    state_ff, state_in;
   logic [63:0]   weight_ff, weight_in;
   logic          out_valid_ff;
   bss_token_type out_tok_ff, out_tok_in;
   logic          match;

   always_comb begin
      state_in   = state_ff;
      weight_in  = weight_ff;
      out_tok_in = in_tok;
      match      = (state_ff == in_tok.code);
      unique case (in_tok.mode)
         MODE_FIND_FIRST: begin
            if (!in_tok.found && match) begin
               out_tok_in.found    = 1'b1;
               out_tok_in.best_idx = cell_index;
            end
         end
         MODE_FIND_OLDEST: begin
            // Strict less-than keeps the lowest index on ties and never picks all ones.
            if (match && (weight_ff != 64'd0) && (weight_ff < in_tok.best)) begin
               out_tok_in.found    = 1'b1;
               out_tok_in.best     = weight_ff;
               out_tok_in.best_idx = cell_index;
            end
         end
         MODE_UPDATE: begin
            if (in_tok.slot == 8'(cell_index)) begin
               out_tok_in.found    = 1'b1;
               out_tok_in.best_idx = cell_index;
               if (in_valid) begin
                  state_in  = in_tok.code;
                  weight_in = in_tok.weight;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= 8'd0;
         weight_ff    <= 64'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         weight_ff    <= weight_in;
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_tok_ff <= out_tok_in;
   end

   assign out_valid = out_valid_ff;
   assign out_tok   = out_tok_ff;

endmodule

/* rtl/core/buffer_slot_selector.sv */
// Top level of the buffer slot selector: a chain of slot cells that a request token walks.
// The result strobe comes from the last cell's output register, after the token has passed every cell.
// The block takes no new request while a token is in flight; busy falls only at the edge that
// takes the result, so the next request goes in only after that edge.
// Reset clears every slot's state and weight to zero and empties the chain at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "buffer_slot_selector_assert.svh"

module buffer_slot_selector
   import bss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  bss_req_type req_data,
   output logic        busy,
   output logic        rsp_strobe,
   output bss_rsp_type rsp_data
);

   // A transfer on the request side happens when start is high and no token is in flight.
   logic accept;
   logic busy_ff, busy_in;

   // Element k of the chain is the token entering cell k; element SLOT_COUNT leaves the last cell.
   logic [SLOT_COUNT:0] chain_valid;
   bss_token_type       chain_tok [SLOT_COUNT+1];
   bss_token_type       last_tok;

   assign accept = start && !busy_ff;

   // The launched token starts with no candidate and the all-ones weight as the best so far,
   // so the oldest-slot search can never settle on an all-ones weight.
   always_comb begin
      chain_valid[0]        = accept;
      chain_tok[0].mode     = req_data.mode;
      chain_tok[0].code     = req_data.state_code;
      chain_tok[0].slot     = req_data.slot_index;
      chain_tok[0].weight   = req_data.new_weight;
      chain_tok[0].best     = WEIGHT_NONE;
      chain_tok[0].found    = 1'b0;
      chain_tok[0].best_idx = '0;
   end

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      bss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_IDX_W'(i)),
         .in_valid   (chain_valid[i]),
         .in_tok     (chain_tok[i]),
         .out_valid  (chain_valid[i+1]),
         .out_tok    (chain_tok[i+1])
      );
   end

   // The block stays busy from the accepting edge until the token leaves the last cell.
   always_comb begin
      priority if (accept) begin
         busy_in = 1'b1;
      end else if (chain_valid[SLOT_COUNT]) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // The last cell's output register holds the result; the index is cut to three bits,
   // and it reads zero when nothing was found or the update slot was out of range.
   assign last_tok          = chain_tok[SLOT_COUNT];
   assign busy              = busy_ff;
   assign rsp_strobe        = chain_valid[SLOT_COUNT];
   assign rsp_data.hit      = last_tok.found;
   assign rsp_data.slot_out = last_tok.found ? 3'(last_tok.best_idx) : 3'd0;

   // Only one token may be in the chain at any time.
   `BSS_ASSERT_SAME(a_single_token, 1'b1, $onehot0(chain_valid[SLOT_COUNT:1]),
                    "more than one token in the cell chain")
   // An accepted request keeps the block busy in the next cycle.
   `BSS_ASSERT_NEXT(a_accept_busy, accept, busy && chain_valid[1],
                    "accepted request did not enter the chain")
   // A result frees the block right after it is shown.
   `BSS_ASSERT_NEXT(a_result_frees, rsp_strobe, !busy && !rsp_strobe,
                    "block still busy after its result")
   // A miss always reports slot zero.
   `BSS_ASSERT_SAME(a_miss_zero, rsp_strobe && !rsp_data.hit, rsp_data.slot_out == 3'd0,
                    "miss reported a nonzero slot")

endmodule

/* verif/tb_buffer_slot_selector.sv */
// Self-checking testbench for the buffer slot selector: directed and random requests.
import bss_pkg::*;

// Scoreboard that keeps its own copy of the slot table. Each accepted request
// is applied to that copy, and the result it should produce is queued. Each
// result strobe is then compared against the oldest queued result.
class slot_table_scoreboard;
   logic [7:0]  slot_state  [SLOT_COUNT];
   logic [63:0] slot_weight [SLOT_COUNT];
   bss_rsp_type pending_results [$];
   int unsigned mismatches;
   int unsigned results_checked;
   int unsigned hits_seen;
   int unsigned requests_by_mode [4];

   // The table starts out cleared, just as it is after reset.
   function void clear_table();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_state[i]  = '0;
         slot_weight[i] = '0;
      end
      for (int m = 0; m < 4; m++) begin
         requests_by_mode[m] = 0;
      end
      mismatches      = 0;
      results_checked = 0;
      hits_seen       = 0;
   endfunction

   function void note_request(bss_req_type req);
      bss_rsp_type expected;
      logic [63:0] oldest;
      expected = '0;
      oldest   = WEIGHT_NONE;
      requests_by_mode[req.mode]++;
      case (req.mode)
         MODE_FIND_FIRST: begin
            // A downward scan leaves the lowest matching index as the answer.
            for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
               if (slot_state[i] == req.state_code) begin
                  expected.hit      = 1'b1;
                  expected.slot_out = 3'(i);
               end
            end
         end
         MODE_FIND_OLDEST: begin
            // A strict compare keeps the lowest index on ties. Because the
            // search starts at all ones, a slot holding all ones never wins.
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_state[i] == req.state_code && slot_weight[i] != '0 &&
                   slot_weight[i] < oldest) begin
                  oldest            = slot_weight[i];
                  expected.hit      = 1'b1;
                  expected.slot_out = 3'(i);
               end
            end
         end
         MODE_UPDATE: begin
            if (req.slot_index < SLOT_COUNT) begin
               slot_state[req.slot_index]  = req.state_code;
               slot_weight[req.slot_index] = req.new_weight;
               expected.hit      = 1'b1;
               expected.slot_out = req.slot_index[2:0];
            end
         end
         default: begin
         end
      endcase
      pending_results.push_back(expected);
   endfunction

   function void check_result(bss_rsp_type got);
      bss_rsp_type expected;
      results_checked++;
      if (got.hit) begin
         hits_seen++;
      end
      if (pending_results.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result hit=%0b slot_out=%0d with no request outstanding",
                  $time, got.hit, got.slot_out);
         return;
      end
      expected = pending_results.pop_front();
      if (got.hit !== expected.hit) begin
         mismatches++;
         $display("%0t: hit mismatch, expected %0b, actual %0b",
                  $time, expected.hit, got.hit);
      end
      if (got.slot_out !== expected.slot_out) begin
         mismatches++;
         $display("%0t: slot_out mismatch, expected %0d, actual %0d",
                  $time, expected.slot_out, got.slot_out);
      end
   endfunction
endclass

module tb_buffer_slot_selector;

   // The package names only the three real modes. The fourth encoding must
   // leave the table alone and report no hit.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // The watchdog gives up after this many cycles in which neither a request
   // nor a result transfer takes place. A correct run never comes close,
   // since a sender gap plus a full pass through the chain is far shorter.
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_REQUESTS = 1450;

   logic        clock    = 1'b0;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   bss_req_type req_data = '0;
   logic        busy;
   logic        rsp_strobe;
   bss_rsp_type rsp_data;

   // Random gaps in the sender are switched off for one long stretch of the
   // random phase, so that requests also arrive back to back.
   logic        idling_on    = 1'b1;
   int unsigned quiet_cycles = 0;

   // Most random requests draw their state code from this small pool, so
   // that searches hit slots that earlier updates have written.
   logic [7:0]  code_pool [4];

   slot_table_scoreboard tracker;

   buffer_slot_selector uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #2 clock = ~clock;

   // Monitor. Both channels are sampled at the rising edge, where the values
   // read are the ones from before the edge. Any result is checked before a
   // request at the same edge is noted. The result of that request comes out
   // only after the token has passed every cell.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            tracker.check_result(rsp_data);
         end
         if (start && !busy) begin
            tracker.note_request(req_data);
         end
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // The watchdog ends the run once nothing has moved for too long.
   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("buffer_slot_selector test failed");
         $finish;
      end
   end

   function automatic bss_req_type build_request(logic [1:0] mode, logic [7:0] code,
                                                 logic [7:0] slot, logic [63:0] weight);
      bss_req_type item;
      item.mode       = mode;
      item.state_code = code;
      item.slot_index = slot;
      item.new_weight = weight;
      return item;
   endfunction

   // Random requests are mostly updates and searches over a small set of
   // codes. Their weights are biased toward zero, all ones and small values,
   // so that ties and skipped slots come up often. Some updates aim at a slot
   // past the end of the table, and a few requests use the unused mode.
   function automatic bss_req_type random_request();
      bss_req_type item;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         item.mode = MODE_UPDATE;
      end else if (pick < 60) begin
         item.mode = MODE_FIND_FIRST;
      end else if (pick < 96) begin
         item.mode = MODE_FIND_OLDEST;
      end else begin
         item.mode = MODE_UNUSED;
      end
      if ($urandom_range(99) < 85) begin
         item.state_code = code_pool[$urandom_range(3)];
      end else begin
         item.state_code = 8'($urandom);
      end
      if ($urandom_range(99) < 90) begin
         item.slot_index = 8'($urandom_range(SLOT_COUNT - 1));
      end else begin
         item.slot_index = 8'($urandom);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
         item.new_weight = '0;
      end else if (pick < 20) begin
         item.new_weight = WEIGHT_NONE;
      end else if (pick < 50) begin
         item.new_weight = 64'($urandom_range(1, 4));
      end else begin
         item.new_weight = {$urandom, $urandom};
      end
      return item;
   endfunction

   // The sender may first hold start low for a random number of cycles. It
   // then presents the request and returns at the edge where the transfer
   // takes place. The task leaves start high, so a following request can be
   // driven at that same edge without start dropping in between.
   task automatic send_request(input bss_req_type item);
      if (idling_on && $urandom_range(99) < 23) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // The sender pauses until every outstanding result has arrived. The first
   // edge gives the monitor time to note the last request before the
   // queue is looked at.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      tracker = new();
      tracker.clear_table();
      code_pool = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed requests. On a cleared table, a search for code zero finds
      // slot zero, but a search for the oldest weight finds nothing, because
      // every weight is still zero.
      send_request(build_request(MODE_FIND_FIRST, 8'h00, 8'h00, '0));
      send_request(build_request(MODE_FIND_OLDEST, 8'h00, 8'h00, '0));
      // A search for a code that no slot holds misses, and so does the unused mode.
      send_request(build_request(MODE_FIND_FIRST, 8'hFF, 8'hFF, WEIGHT_NONE));
      send_request(build_request(MODE_UNUSED, 8'hFF, 8'hFF, WEIGHT_NONE));
      // Updates to a slot just past the end and at the top of the index range are dropped.
      send_request(build_request(MODE_UPDATE, 8'hFF, 8'(SLOT_COUNT), WEIGHT_NONE));
      send_request(build_request(MODE_UPDATE, 8'hFF, 8'hFF, WEIGHT_NONE));
      // A slot that holds the all-ones weight can be found by code, but not by age.
      send_request(build_request(MODE_UPDATE, 8'hFF, 8'(SLOT_COUNT - 1), WEIGHT_NONE));
      send_request(build_request(MODE_FIND_OLDEST, 8'hFF, 8'h00, '0));
      send_request(build_request(MODE_FIND_FIRST, 8'hFF, 8'h00, '0));
      // Of three slots with the same code, the one with zero weight is the
      // first match by code, but it is skipped by the search for the oldest.
      send_request(build_request(MODE_UPDATE, 8'hA5, 8'd1, '0));
      send_request(build_request(MODE_UPDATE, 8'hA5, 8'd3, 64'h8000_0000_0000_0000));
      send_request(build_request(MODE_UPDATE, 8'hA5, 8'd5, 64'hFFFF_FFFF_FFFF_FFFE));
      send_request(build_request(MODE_FIND_OLDEST, 8'hA5, 8'h00, '0));
      send_request(build_request(MODE_FIND_FIRST, 8'hA5, 8'h00, '0));
      // When two slots hold equal weights, the lower index wins. After that,
      // the smallest nonzero weight takes over.
      send_request(build_request(MODE_UPDATE, 8'hA5, 8'd6, 64'h8000_0000_0000_0000));
      send_request(build_request(MODE_FIND_OLDEST, 8'hA5, 8'h00, '0));
      send_request(build_request(MODE_UPDATE, 8'hA5, 8'd2, 64'd1));
      send_request(build_request(MODE_FIND_OLDEST, 8'hA5, 8'h00, '0));
      send_request(build_request(MODE_UPDATE, 8'h00, 8'd0, '0));
      send_request(build_request(MODE_UPDATE, 8'h5A, 8'd4, 64'h5555_AAAA_0F0F_F0F0));
      send_request(build_request(MODE_FIND_OLDEST, 8'h5A, 8'h00, '0));
      send_request(build_request(MODE_UNUSED, 8'($urandom), 8'($urandom), {$urandom, $urandom}));
      wait_for_results();

      // Random phase. Every few hundred requests the sender drains all
      // outstanding results, and it sends with no gaps for one long stretch.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idling_on = !(n >= 500 && n < 800);
         if (n % 300 == 299) begin
            wait_for_results();
         end
         send_request(random_request());
      end

      // Wait for the last result, then a little longer, so that any stray
      // extra strobe would still be caught.
      wait_for_results();
      repeat (SLOT_COUNT + 4) @(posedge clock);

      $display("Requests sent: %0d find-first, %0d find-oldest, %0d update, %0d unused mode.",
               tracker.requests_by_mode[MODE_FIND_FIRST],
               tracker.requests_by_mode[MODE_FIND_OLDEST],
               tracker.requests_by_mode[MODE_UPDATE],
               tracker.requests_by_mode[MODE_UNUSED]);
      $display("Results checked: %0d, of which %0d were hits; %0d mismatches found.",
               tracker.results_checked, tracker.hits_seen, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("buffer_slot_selector test passed");
      end else begin
         $display("buffer_slot_selector test failed");
      end
      $finish;
   end

endmodule
